// ----- rtl/atcr_pkg.sv -----
// Shared request codes, character codes, match type and hex helpers for the AT responder.
`timescale 1ns / 1ps

package atcr_pkg;

	localparam logic [1:0] REQ_WRITE      = 2'd0;
	localparam logic [1:0] REQ_READ       = 2'd1;
	localparam logic [1:0] REQ_SET_REPORT = 2'd2;
	localparam logic [1:0] REQ_SET_EVENT  = 2'd3;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;

	// only the leading bytes of a line are ever compared or decoded
	localparam int LINE_KEEP = 8;

	typedef struct packed {
		logic        is_report;
		logic        is_event;
		logic        is_sleep;
		logic        is_timer;
		logic [15:0] timer_value;
	} atcr_match_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] base;
		base = (n < 4'd10) ? CH_ZERO : (CH_A - 8'd10);
		return base + {4'd0, n};
	endfunction

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
		end else if (c >= CH_A && c <= CH_F) begin
			v = c - CH_A + 8'd10;
		end else if (c >= CH_LC_A && c <= CH_LC_F) begin
			v = c - CH_LC_A + 8'd10;
		end
		return v[3:0];
	endfunction

endpackage

// ----- rtl/atcr_parse.sv -----
// Command line matcher: compares the head of the line with the fixed commands.
`timescale 1ns / 1ps

module atcr_parse import atcr_pkg::*; #(
	parameter int CNT_W = 5
) (
	input  logic [LINE_KEEP-1:0][7:0] head,
	input  logic [CNT_W-1:0]          count,
	output atcr_match_t               match
);

	logic       len4;
	logic       at_ok;
	logic [3:0] nib [4];

	assign len4  = count >= CNT_W'(4);
	assign at_ok = head[0] == CH_A && head[1] == CH_T;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			nib[k] = (count > CNT_W'(4 + k)) ? hex_digit(head[4 + k]) : 4'd0;
		end
	end

	always_comb begin
		match.is_report = len4 && at_ok && head[2] == CH_D && head[3] == CH_QM;
		match.is_event  = len4 && at_ok && head[2] == CH_E && head[3] == CH_QM;
		match.is_sleep  = count == CNT_W'(8) && at_ok && head[2] == CH_EQ &&
			head[3] == CH_S && head[4] == CH_L && head[5] == CH_E &&
			head[6] == CH_E && head[7] == CH_P;
		match.is_timer  = len4 && at_ok && head[2] == CH_S && head[3] == CH_EQ;
		match.timer_value = match.is_timer ? {nib[0], nib[1], nib[2], nib[3]} : 16'd0;
	end

endmodule

// ----- rtl/at_command_line_responder.sv -----
// Top level of the AT command line responder: request register, state stores, result register.
//
//  channel | signals                      | payload
//  --------+------------------------------+-------------------------------------------
//  s_*     | s_tvalid s_tready s_tdata    | one request: write, read or set a byte
//          | s_tuser                      |
//  m_*     | m_tvalid m_tready m_tdata    | one result per request
//
// Each request passes through the request register and then the result
// register; a new request is taken every cycle while m_tready is high.
// A stalled result holds the request register; s_tready drops only then.
// arst_n clears the line count, the reply pointer and length, and the
// report and event bytes.
`timescale 1ns / 1ps

module at_command_line_responder import atcr_pkg::*; #(
	parameter int RX_DEPTH   = 16,
	parameter int TX_DEPTH   = 16,
	parameter int REPORT_LEN = 4,
	parameter int EVENT_LEN  = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte[7:0], byte_index[10:8], zero[15:11]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // read_byte[7:0], line_done[8], sleep_request[9],
	                              // timer_load[10], timer_value[26:11], zero[31:27]
);

	localparam int CNT_W     = $clog2(RX_DEPTH + 1);
	localparam int MAX_LEN   = (REPORT_LEN > EVENT_LEN) ? REPORT_LEN : EVENT_LEN;
	localparam int REPLY_D   = 2 * MAX_LEN + 2;
	localparam int POS_W     = $clog2(REPLY_D);
	localparam int LEN_W     = $clog2(REPLY_D + 1);
	localparam bit FIT_R     = (1 + 2 * REPORT_LEN) < TX_DEPTH;
	localparam int BODY_R    = FIT_R ? 1 + 2 * REPORT_LEN : 1;
	localparam bit CR_R      = (BODY_R + 1) < TX_DEPTH;
	localparam int LEN_R     = BODY_R + (CR_R ? 1 : 0);
	localparam bit FIT_E     = (1 + 2 * EVENT_LEN) < TX_DEPTH;
	localparam int BODY_E    = FIT_E ? 1 + 2 * EVENT_LEN : 1;
	localparam bit CR_E      = (BODY_E + 1) < TX_DEPTH;
	localparam int LEN_E     = BODY_E + (CR_E ? 1 : 0);

	// request register
	logic        valid_s1;
	logic [1:0]  type_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  idx_s1;

	// state
	logic [LINE_KEEP-1:0][7:0] line_q;
	logic [CNT_W-1:0]          count_q;
	logic [7:0]                reply_q [REPLY_D];
	logic [POS_W-1:0]          pos_q;
	logic [LEN_W-1:0]          len_q;
	logic [7:0]                report_q [REPORT_LEN];
	logic [7:0]                event_q [EVENT_LEN];

	// result register
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic        advance;
	logic        fire;
	logic        is_end;
	atcr_match_t match;
	logic [7:0]  reply_d [REPLY_D];
	logic [LEN_W-1:0] len_end;
	logic [CNT_W-1:0] count_inc;
	logic [LEN_W-1:0] pos_inc;
	logic        rd_empty;
	logic [7:0]  rd_byte;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;
	assign is_end   = type_s1 == REQ_WRITE && (byte_s1 == CH_CR || byte_s1 == CH_LF);

	atcr_parse #(.CNT_W(CNT_W)) u_parse (
		.head  (line_q),
		.count (count_q),
		.match (match)
	);

	// response built at line end: report or event bytes in hex, else +OK
	always_comb begin
		for (int p = 0; p < REPLY_D; p++) begin
			reply_d[p] = reply_q[p];
		end
		len_end = LEN_W'(4);
		if (match.is_report) begin
			reply_d[0] = CH_PLUS;
			if (FIT_R) begin
				for (int i = 0; i < REPORT_LEN; i++) begin
					reply_d[POS_W'(1 + 2 * i)] = hex_char(report_q[i][7:4]);
					reply_d[POS_W'(2 + 2 * i)] = hex_char(report_q[i][3:0]);
				end
			end
			if (CR_R) begin
				reply_d[POS_W'(LEN_R - 1)] = CH_CR;
			end
			len_end = LEN_W'(LEN_R);
		end else if (match.is_event) begin
			reply_d[0] = CH_PLUS;
			if (FIT_E) begin
				for (int i = 0; i < EVENT_LEN; i++) begin
					reply_d[POS_W'(1 + 2 * i)] = hex_char(event_q[i][7:4]);
					reply_d[POS_W'(2 + 2 * i)] = hex_char(event_q[i][3:0]);
				end
			end
			if (CR_E) begin
				reply_d[POS_W'(LEN_E - 1)] = CH_CR;
			end
			len_end = LEN_W'(LEN_E);
		end else begin
			reply_d[0] = CH_PLUS;
			reply_d[1] = CH_O;
			reply_d[2] = CH_K;
			reply_d[3] = CH_CR;
		end
	end

	assign count_inc = count_q + 1'b1;
	assign pos_inc   = LEN_W'(pos_q) + 1'b1;
	assign rd_empty  = len_q == '0 || LEN_W'(pos_q) >= len_q;
	assign rd_byte   = rd_empty ? CH_CR : reply_q[pos_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			type_s1 <= s_tuser;
			byte_s1 <= s_tdata[7:0];
			idx_s1  <= s_tdata[10:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= '0;
			count_q <= '0;
			pos_q   <= '0;
			len_q   <= '0;
			for (int i = 0; i < REPORT_LEN; i++) begin
				report_q[i] <= 8'd0;
			end
			for (int i = 0; i < EVENT_LEN; i++) begin
				event_q[i] <= 8'd0;
			end
		end else if (fire) begin
			case (type_s1)
				REQ_WRITE: begin
					if (is_end) begin
						count_q <= '0;
						pos_q   <= '0;
						len_q   <= len_end;
						if (match.is_sleep) begin
							for (int i = 0; i < REPORT_LEN; i++) begin
								report_q[i] <= 8'd0;
							end
							for (int i = 0; i < EVENT_LEN; i++) begin
								event_q[i] <= 8'd0;
							end
						end
					end else begin
						if (count_q < CNT_W'(LINE_KEEP)) begin
							line_q[count_q[2:0]] <= byte_s1;
						end
						count_q <= (count_inc == CNT_W'(RX_DEPTH)) ? '0 : count_inc;
					end
				end
				REQ_READ: begin
					if (rd_empty || pos_inc >= len_q) begin
						pos_q <= '0;
						len_q <= '0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				REQ_SET_REPORT: begin
					for (int i = 0; i < REPORT_LEN; i++) begin
						if (idx_s1 == 3'(i)) begin
							report_q[i] <= byte_s1;
						end
					end
				end
				default: begin
					for (int i = 0; i < EVENT_LEN; i++) begin
						if (idx_s1 == 3'(i)) begin
							event_q[i] <= byte_s1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_end) begin
			for (int p = 0; p < REPLY_D; p++) begin
				reply_q[p] <= reply_d[p];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {5'd0,
				is_end ? match.timer_value : 16'd0,
				is_end && match.is_timer && !match.is_sleep,
				is_end && match.is_sleep,
				is_end,
				(type_s1 == REQ_READ) ? rd_byte : 8'd0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(RX_DEPTH))
		else $error("line count out of range");

	a_pos_len: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0 && pos_q == '0) || (LEN_W'(pos_q) < len_q))
		else $error("reply pointer beyond reply length");

	a_sleep_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q[9] || out_data_q[10]) |-> out_data_q[8] &&
		!(out_data_q[9] && out_data_q[10]) && out_data_q[7:0] == 8'd0)
		else $error("command flags without a line end");

	a_end_reply: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_end |=> len_q != '0 && pos_q == '0)
		else $error("line end left no response");

endmodule

// ----- dv/atcr_checker.sv -----
// Checker for the AT command responder: follows every request, predicts its result, compares.
`timescale 1ns / 1ps

module atcr_checker import atcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte[7:0], byte_index[10:8], zero[15:11]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // read_byte[7:0], line_done[8], sleep_request[9],
	                              // timer_load[10], timer_value[26:11], zero[31:27]
	output int          fail_count,
	output int          pending_count
);

	localparam int RX_DEPTH   = 16;
	localparam int TX_DEPTH   = 16;
	localparam int REPORT_LEN = 4;
	localparam int EVENT_LEN  = 1;

	// highest field first, so the layout matches m_tdata[26:0]
	typedef struct packed {
		logic [15:0] timer_value;
		logic        timer_load;
		logic        sleep_request;
		logic        line_done;
		logic [7:0]  read_byte;
	} resp_t;

	logic [7:0] line_buf [RX_DEPTH];
	int         line_len;
	logic [7:0] tx_buf [TX_DEPTH];
	int         tx_pos;
	int         tx_len;
	logic [7:0] report_val [REPORT_LEN];
	logic [7:0] event_val [EVENT_LEN];
	resp_t      result_due_q [$];
	string      hex_digits = "0123456789ABCDEF";

	function automatic void clear_state();
		line_len = 0;
		tx_pos   = 0;
		tx_len   = 0;
		foreach (line_buf[i]) line_buf[i] = 8'd0;
		foreach (tx_buf[i]) tx_buf[i] = 8'd0;
		foreach (report_val[i]) report_val[i] = 8'd0;
		foreach (event_val[i]) event_val[i] = 8'd0;
	endfunction

	function automatic bit line_has_prefix(input string pat);
		if (line_len < pat.len())
			return 1'b0;
		for (int i = 0; i < pat.len(); i++)
			if (line_buf[i] != pat[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// bad characters and positions past the line end give zero
	function automatic logic [3:0] digit_val(input int pos);
		logic [7:0] c;
		if (pos >= line_len)
			return 4'd0;
		c = line_buf[pos];
		if (c >= CH_ZERO && c <= CH_NINE)
			return 4'(c - CH_ZERO);
		if (c >= CH_A && c <= CH_F)
			return 4'(c - CH_A + 8'd10);
		if (c >= CH_LC_A && c <= CH_LC_F)
			return 4'(c - CH_LC_A + 8'd10);
		return 4'd0;
	endfunction

	function automatic void put_tx(input logic [7:0] c);
		if (tx_len < TX_DEPTH) begin
			tx_buf[tx_len] = c;
			tx_len++;
		end
	endfunction

	function automatic void load_hex_reply(input bit from_event);
		int         n;
		logic [7:0] v;
		n = from_event ? EVENT_LEN : REPORT_LEN;
		tx_len = 0;
		put_tx(CH_PLUS);
		if (tx_len + 2 * n < TX_DEPTH) begin
			for (int i = 0; i < n; i++) begin
				if (from_event)
					v = event_val[i];
				else
					v = report_val[i];
				put_tx(hex_digits[v[7:4]]);
				put_tx(hex_digits[v[3:0]]);
			end
		end
		if (tx_len + 1 < TX_DEPTH)
			put_tx(CH_CR);
	endfunction

	function automatic resp_t respond_to_request(input logic [1:0] kind, input logic [7:0] b,
	                                             input logic [2:0] idx);
		resp_t r;
		r = '0;
		case (kind)
			REQ_WRITE: begin
				if (b == CH_CR || b == CH_LF) begin
					r.line_done = 1'b1;
					if (line_has_prefix("ATD?")) begin
						load_hex_reply(1'b0);
					end else if (line_has_prefix("ATE?")) begin
						load_hex_reply(1'b1);
					end else begin
						tx_len = 0;
						put_tx(CH_PLUS);
						put_tx(CH_O);
						put_tx(CH_K);
						put_tx(CH_CR);
					end
					tx_pos = 0;
					if (line_len == 8 && line_has_prefix("AT=SLEEP")) begin
						foreach (report_val[i]) report_val[i] = 8'd0;
						foreach (event_val[i]) event_val[i] = 8'd0;
						r.sleep_request = 1'b1;
					end else if (line_has_prefix("ATS=")) begin
						r.timer_load  = 1'b1;
						r.timer_value = {digit_val(4), digit_val(5), digit_val(6), digit_val(7)};
					end
					line_len = 0;
				end else begin
					// line wraps after RX_DEPTH characters
					line_buf[line_len] = b;
					line_len++;
					if (line_len >= RX_DEPTH)
						line_len = 0;
				end
			end
			REQ_READ: begin
				if (tx_len == 0 || tx_pos >= tx_len) begin
					r.read_byte = CH_CR;
					tx_pos = 0;
					tx_len = 0;
				end else begin
					r.read_byte = tx_buf[tx_pos];
					tx_pos++;
					if (tx_pos >= tx_len) begin
						tx_pos = 0;
						tx_len = 0;
					end
				end
			end
			REQ_SET_REPORT: begin
				if (idx < REPORT_LEN)
					report_val[idx] = b;
			end
			REQ_SET_EVENT: begin
				if (idx < EVENT_LEN)
					event_val[idx] = b;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		resp_t got;
		resp_t want;
		if (!arst_n) begin
			clear_state();
			result_due_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[26:0];
				if (result_due_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with no request pending, actual %h", $time, m_tdata);
				end else begin
					want = result_due_q.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: mismatch expected rd=%h done=%b sleep=%b load=%b tval=%h",
						         $time, want.read_byte, want.line_done, want.sleep_request,
						         want.timer_load, want.timer_value);
						$display("%0t:          actual   rd=%h done=%b sleep=%b load=%b tval=%h",
						         $time, got.read_byte, got.line_done, got.sleep_request,
						         got.timer_load, got.timer_value);
					end
				end
			end
			if (s_tvalid && s_tready)
				result_due_q.push_back(respond_to_request(s_tuser, s_tdata[7:0], s_tdata[10:8]));
		end
		pending_count = result_due_q.size();
	end

endmodule

// ----- dv/tb_at_command_line_responder.sv -----
// Testbench top for the AT command responder: reset, request stimulus, result sink, verdict.
`timescale 1ns / 1ps

module tb_at_command_line_responder import atcr_pkg::*; ();

	localparam int REQUEST_TARGET = 1300;
	localparam int CYCLE_LIMIT    = 200000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = 16'd0;  // data_byte[7:0], byte_index[10:8], zero[15:11]
	logic [1:0]  s_tuser  = 2'd0;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // read_byte[7:0], line_done[8], sleep_request[9],
	                                // timer_load[10], timer_value[26:11], zero[31:27]

	int         fail_count;
	int         pending_count;
	int         sent_count  = 0;
	int         cycle_count = 0;
	bit         no_idle     = 1'b0;
	logic [7:0] line_chars [$];

	always #4 clk = ~clk;

	at_command_line_responder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	atcr_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_req(input logic [1:0] kind, input logic [7:0] b, input logic [2:0] idx);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, idx, b};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
	endtask

	task automatic send_line(input bit use_lf);
		foreach (line_chars[i])
			send_req(REQ_WRITE, line_chars[i], 3'($urandom_range(0, 7)));
		send_req(REQ_WRITE, use_lf ? CH_LF : CH_CR, 3'($urandom_range(0, 7)));
	endtask

	task automatic read_reply(input int n);
		repeat (n) send_req(REQ_READ, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
	endtask

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_CR || c == CH_LF);
		return c;
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_chars.push_back(s[i]);
	endfunction

	function automatic void add_junk(input int n);
		repeat (n) line_chars.push_back(junk_char());
	endfunction

	function automatic void add_hex(input int n);
		string ok;
		ok = "0123456789abcdefABCDEF";
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				line_chars.push_back(junk_char());
			else
				line_chars.push_back(ok[$urandom_range(0, 21)]);
		end
	endfunction

	function automatic void build_random_line();
		line_chars.delete();
		case ($urandom_range(0, 9))
			0: add_text("ATD?");
			1: add_text("ATE?");
			2: add_text("AT=SLEEP");
			3, 4: begin
				add_text("ATS=");
				add_hex($urandom_range(0, 5));
			end
			5: begin
				if ($urandom_range(0, 1))
					add_text("ATD?");
				else
					add_text("ATE?");
				add_junk($urandom_range(1, 3));
			end
			6: begin
				if ($urandom_range(0, 1))
					add_text("AT=SLEE");
				else
					add_text("AT=SLEEPS");
			end
			7: add_junk($urandom_range(0, 20));
			8: begin
				// overflow: the write position wraps before or inside the command
				add_junk($urandom_range(14, 18));
				if ($urandom_range(0, 1)) begin
					add_text("ATS=");
					add_hex(4);
				end else begin
					add_text("ATD?");
				end
			end
			9: begin
				add_text("AT=SLEEP");
				line_chars[$urandom_range(0, 7)] = junk_char();
			end
		endcase
	endfunction

	initial begin : sink
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte sets incl. out-of-range indexes, ATE? reply and over-read,
		// short ATS= digits, then a reply that is read only in part
		send_req(REQ_SET_REPORT, 8'hFF, 3'd0);
		send_req(REQ_SET_REPORT, 8'h3C, 3'd7);
		send_req(REQ_SET_EVENT, 8'hA5, 3'd0);
		send_req(REQ_SET_EVENT, 8'h00, 3'd1);
		line_chars.delete();
		add_text("ATE?");
		send_line(1'b1);
		read_reply(5);
		line_chars.delete();
		add_text("ATS=fA0");
		send_line(1'b0);
		read_reply(1);

		while (sent_count < REQUEST_TARGET) begin
			no_idle = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1: repeat ($urandom_range(1, 3))
					send_req($urandom_range(0, 1) ? REQ_SET_EVENT : REQ_SET_REPORT,
					         8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
				2: repeat ($urandom_range(1, 4))
					send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					         3'($urandom_range(0, 7)));
				default: begin
					build_random_line();
					send_line(1'($urandom_range(0, 1)));
					read_reply($urandom_range(0, 12));
				end
			endcase
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;

		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
